// ----- design/ell_sparse_matrix_vector_multiply_macros.svh -----
// Assertion macros used by the checker file of the sparse matrix-vector block
`ifndef ELL_SPARSE_MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define ELL_SPARSE_MATRIX_VECTOR_MULTIPLY_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ELLSPMV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ellspmv check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ELLSPMV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ellspmv check failed");

`endif

// ----- design/ellspmv_pkg.sv -----
// Types and constants of the ELLPACK sparse matrix-vector multiplier
package ellspmv_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned ROW_W     = 16;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned VIDX_W    = 10;
  localparam int unsigned COL_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [COL_W-1:0]  COL_PADDING  = '1;
  localparam logic [LEN_W-1:0]  VLEN_RESET   = 11'd1024;
  localparam logic [ROW_W-1:0]  ROWS_RESET   = 16'd1;
  localparam logic [DATA_W-1:0] SUM_MAX      = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SUM_MIN      = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VECTOR_LENGTH = 2'd0,
    CFG_ROW_COUNT     = 2'd1
  } cfg_index_e;

  // Control of one matrix slot as it enters the MAC pipeline
  typedef struct packed {
    logic valid;
    logic acc_en;
    logic bad;
    logic last;
  } slot_ctrl_t;

  // A finished row, ready for the output register
  typedef struct packed {
    logic              valid;
    logic [ROW_W-1:0]  row;
    logic [DATA_W-1:0] sum;
    logic              ovf;
    logic              bad;
  } row_result_t;

endpackage

// ----- design/ellspmv_vstore.sv -----
// Dense vector store: single-port-write, registered-read synchronous memory
module ellspmv_vstore #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // hold the read word while the pipeline is frozen
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- design/ellspmv_mac.sv -----
// Multiply-accumulate pipeline: product, Q16.16 truncation, row sum and saturation
module ellspmv_mac (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        adv_i,
  input  ellspmv_pkg::slot_ctrl_t                     slot_i,
  input  logic signed [ellspmv_pkg::DATA_W-1:0]       value_i,
  input  logic        [ellspmv_pkg::DATA_W-1:0]       vec_i,
  input  logic        [ellspmv_pkg::ROW_W-1:0]        row_count_i,
  output ellspmv_pkg::row_result_t                    result_o
);
  import ellspmv_pkg::*;

  slot_ctrl_t               s1_q, s2_q;
  logic signed [DATA_W-1:0] s1_value_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;

  logic [ACC_W-1:0] acc_q, acc_d, acc_sum, addend;
  logic             bad_seen_q, bad_seen_d, bad_cur;
  logic [ROW_W-1:0] row_q, row_d;
  logic [ROW_W:0]   row_inc;

  logic              s3_valid_q;
  logic [ACC_W-1:0]  s3_sum_q;
  logic [ROW_W-1:0]  s3_row_q;
  logic              s3_bad_q;
  logic [ACC_W-DATA_W:0] sum_top;
  logic              ovf;

  // stage 1: slot control and value, aligned with the vector read word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (adv_i) begin
      s1_q <= slot_i;
      s2_q <= s1_q;
    end
  end

  assign prod_d = s1_value_q * $signed(vec_i);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_value_q <= value_i;
      prod_q     <= prod_d;
    end
  end

  // stage 3: arithmetic shift by the fraction width, then add into the row sum
  always_comb begin
    addend   = s2_q.acc_en ? prod_q[FRAC_W +: ACC_W] : '0;
    acc_sum  = acc_q + addend;
    bad_cur  = bad_seen_q | s2_q.bad;
    row_inc  = {1'b0, row_q} + {{ROW_W{1'b0}}, 1'b1};
    acc_d      = acc_q;
    bad_seen_d = bad_seen_q;
    row_d      = row_q;
    if (s2_q.valid) begin
      acc_d      = s2_q.last ? '0 : acc_sum;
      bad_seen_d = s2_q.last ? 1'b0 : bad_cur;
      if (s2_q.last) begin
        row_d = (row_inc >= {1'b0, row_count_i}) ? '0 : row_inc[ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      bad_seen_q <= 1'b0;
      row_q      <= '0;
      s3_valid_q <= 1'b0;
    end else if (adv_i) begin
      acc_q      <= acc_d;
      bad_seen_q <= bad_seen_d;
      row_q      <= row_d;
      s3_valid_q <= s2_q.valid & s2_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_sum_q <= acc_sum;
      s3_row_q <= row_q;
      s3_bad_q <= bad_cur;
    end
  end

  // saturate: the sum fits when the result's sign bit and all bits above it agree
  assign sum_top = s3_sum_q[ACC_W-1:DATA_W-1];
  assign ovf     = ~((&sum_top) | (~|sum_top));

  always_comb begin
    result_o.valid = s3_valid_q;
    result_o.row   = s3_row_q;
    result_o.ovf   = ovf;
    result_o.bad   = s3_bad_q;
    if (!ovf) begin
      result_o.sum = s3_sum_q[DATA_W-1:0];
    end else begin
      result_o.sum = s3_sum_q[ACC_W-1] ? SUM_MIN : SUM_MAX;
    end
  end

endmodule

// ----- design/ell_sparse_matrix_vector_multiply.sv -----
// A row result passes the MAC stage registers and then the output register before it is shown.
// Throughput: one word (vector element or matrix slot) per cycle; the rate is set
// by the single vector-store read port and one 32x32 multiply-accumulate per cycle.
// Input stalls only while a finished row waits behind a stalled output word.
// Reset clears the pipeline, row sum, row counter and flags; vector_length goes to
// 1024 and row_count to 1. The vector store holds no reset value until written.
module ell_sparse_matrix_vector_multiply #(
  parameter int unsigned VECTOR_DEPTH = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [ellspmv_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ellspmv_pkg::CFG_DAT_W-1:0]        cfg_data_i,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic                                     kind_i,
  input  logic [ellspmv_pkg::VIDX_W-1:0]           vector_index_i,
  input  logic signed [ellspmv_pkg::COL_W-1:0]     column_index_i,
  input  logic signed [ellspmv_pkg::DATA_W-1:0]    data_value_i,
  input  logic                                     last_in_row_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic [ellspmv_pkg::ROW_W-1:0]            row_number_o,
  output logic signed [ellspmv_pkg::DATA_W-1:0]    row_sum_o,
  output logic                                     overflow_o,
  output logic                                     bad_index_o
);
  import ellspmv_pkg::*;

  localparam int unsigned AW    = $clog2(VECTOR_DEPTH);
  localparam int unsigned XW    = 17;
  localparam logic [XW-1:0] DEPTH_X = XW'(VECTOR_DEPTH);

  logic [LEN_W-1:0] vlen_q, vlen_d;
  logic [ROW_W-1:0] rows_q, rows_d;

  logic        adv, in_acc;
  logic [XW-1:0] vidx_x, col_x;
  logic        vidx_ok, padding, col_bad, wr_en;
  slot_ctrl_t  slot;
  row_result_t res, out_q;
  logic        out_valid_q;
  logic [DATA_W-1:0] vec_rd;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    vlen_d = vlen_q;
    rows_d = rows_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_VECTOR_LENGTH: vlen_d = cfg_data_i[LEN_W-1:0];
        CFG_ROW_COUNT:     rows_d = cfg_data_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q <= VLEN_RESET;
      rows_q <= ROWS_RESET;
    end else begin
      vlen_q <= vlen_d;
      rows_q <= rows_d;
    end
  end

  // freeze the whole pipe only when a finished row cannot enter the output register
  assign adv        = ~(res.valid & out_valid_q & out_stall_i);
  assign in_stall_o = ~adv;
  assign in_acc     = in_valid_i & adv;

  assign vidx_x  = {{(XW-VIDX_W){1'b0}}, vector_index_i};
  assign col_x   = {{(XW-COL_W){1'b0}}, column_index_i};
  assign vidx_ok = vidx_x < DEPTH_X;
  assign padding = column_index_i == COL_PADDING;
  assign col_bad = column_index_i[COL_W-1]
                 | (column_index_i >= vlen_q)
                 | (col_x >= DEPTH_X);
  assign wr_en   = in_acc & ~kind_i & vidx_ok;

  always_comb begin
    slot.valid  = in_acc & kind_i;
    slot.acc_en = ~padding & ~col_bad;
    slot.bad    = ~padding & col_bad;
    slot.last   = last_in_row_i;
  end

  ellspmv_vstore #(
    .DEPTH (VECTOR_DEPTH),
    .WIDTH (DATA_W)
  ) u_vstore (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (vidx_x[AW-1:0]),
    .wr_data_i (data_value_i),
    .rd_en_i   (adv),
    .rd_addr_i (col_x[AW-1:0]),
    .rd_data_o (vec_rd)
  );

  ellspmv_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .slot_i      (slot),
    .value_i     (data_value_i),
    .vec_i       (vec_rd),
    .row_count_i (rows_q),
    .result_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid & adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid & adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_number_o = out_q.row;
  assign row_sum_o    = $signed(out_q.sum);
  assign overflow_o   = out_q.ovf;
  assign bad_index_o  = out_q.bad;

endmodule

// ----- design/ellspmv_checker.sv -----
// Port-level checks of the sparse matrix-vector block, bound to its top level
`include "ell_sparse_matrix_vector_multiply_macros.svh"

module ellspmv_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_stall_o,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic [ellspmv_pkg::ROW_W-1:0]         row_number_o,
  input logic signed [ellspmv_pkg::DATA_W-1:0] row_sum_o,
  input logic                                  overflow_o,
  input logic                                  bad_index_o
);
  import ellspmv_pkg::*;

  logic [ROW_W+DATA_W+1:0] out_word;
  logic                    sum_at_end;

  assign out_word   = {row_number_o, row_sum_o, overflow_o, bad_index_o};
  assign sum_at_end = (row_sum_o == $signed(SUM_MAX)) || (row_sum_o == $signed(SUM_MIN));

  // a stalled output word stays offered
  `ELLSPMV_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // a stalled output word does not change
  `ELLSPMV_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_word))

  // a saturated sum sits at one end of the range
  `ELLSPMV_ASSERT_NOW(a_sat_value, out_valid_o && overflow_o, sum_at_end)

  // the input stalls only behind a held output word
  `ELLSPMV_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

endmodule

bind ell_sparse_matrix_vector_multiply ellspmv_checker u_checker (.*);

// ----- verif/tb.sv -----
// Self-checking testbench of the ELLPACK sparse matrix-vector multiplier, with a row-sum predictor
`timescale 1ns / 100ps

module tb;
  import ellspmv_pkg::*;

  typedef enum logic {
    KIND_VEC_WRITE = 1'b0,
    KIND_SLOT      = 1'b1
  } word_kind_e;

  // One input word as it crosses the handshake
  typedef struct packed {
    logic              kind;
    logic [VIDX_W-1:0] vidx;
    logic [COL_W-1:0]  col;
    logic [DATA_W-1:0] data;
    logic              last;
  } in_word_t;

  // One finished row
  typedef struct packed {
    logic [ROW_W-1:0]  row_number;
    logic [DATA_W-1:0] row_sum;
    logic              overflow;
    logic              bad_index;
  } row_word_t;

  localparam int unsigned               STORE_DEPTH = 1024;
  localparam int unsigned               DRAIN_WAIT  = 8;
  localparam int unsigned               STUCK_LIMIT = 2000;
  localparam int unsigned               LONG_HOLD   = 60;
  localparam logic signed [ACC_W-1:0]   ACC_HI      = 48'sh0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0]   ACC_LO      = 48'shFFFF_8000_0000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = CFG_VECTOR_LENGTH;
  logic [CFG_DAT_W-1:0]     cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     kind_i = KIND_VEC_WRITE;
  logic [VIDX_W-1:0]        vector_index_i = '0;
  logic signed [COL_W-1:0]  column_index_i = '0;
  logic signed [DATA_W-1:0] data_value_i = '0;
  logic                     last_in_row_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [ROW_W-1:0]         row_number_o;
  logic signed [DATA_W-1:0] row_sum_o;
  logic                     overflow_o;
  logic                     bad_index_o;

  // Predictor state
  logic signed [DATA_W-1:0] vec_store [STORE_DEPTH];
  bit                       vec_written [STORE_DEPTH];
  logic [ACC_W-1:0]         row_acc;
  logic [ROW_W-1:0]         cur_row;
  logic                     bad_seen;
  logic [LEN_W-1:0]         vlen;
  logic [ROW_W-1:0]         rows;

  row_word_t   expected_rows [$];
  in_word_t    directed_words [$];
  bit          directed_typed [$];
  row_word_t   directed_rows [$];
  int unsigned mismatches = 0;

  // Idling control
  bit          calm = 1'b0;
  bit          tx_calm = 1'b0;
  int unsigned tx_count = 0;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned rx_mode_left = 0;
  bit          rx_calm = 1'b0;
  int unsigned stuck_cycles = 0;

  ell_sparse_matrix_vector_multiply DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .vector_index_i (vector_index_i),
    .column_index_i (column_index_i),
    .data_value_i   (data_value_i),
    .last_in_row_i  (last_in_row_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .row_number_o   (row_number_o),
    .row_sum_o      (row_sum_o),
    .overflow_o     (overflow_o),
    .bad_index_o    (bad_index_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Advance the predictor by one accepted word; returns 1 when a row completes
  function automatic bit predict_row_sum(input in_word_t w, output row_word_t r);
    logic signed [2*DATA_W-1:0] prod;
    logic signed [ACC_W-1:0]    acc_s;
    logic [ROW_W:0]             next_row;
    r = '0;
    if (w.kind == KIND_VEC_WRITE) begin
      vec_store[w.vidx] = w.data;
      vec_written[w.vidx] = 1'b1;
      return 1'b0;
    end
    if (w.col != COL_PADDING) begin
      if (w.col[COL_W-1] || w.col >= vlen) begin
        bad_seen = 1'b1;
      end else begin
        prod = $signed(w.data) * vec_store[w.col[VIDX_W-1:0]];
        // floor shift by the fraction width, keep 48 bits
        row_acc = row_acc + prod[2*DATA_W-1:FRAC_W];
      end
    end
    if (!w.last) return 1'b0;
    acc_s = row_acc;
    r.row_number = cur_row;
    r.bad_index = bad_seen;
    if (acc_s > ACC_HI) begin
      r.row_sum = SUM_MAX;
      r.overflow = 1'b1;
    end else if (acc_s < ACC_LO) begin
      r.row_sum = SUM_MIN;
      r.overflow = 1'b1;
    end else begin
      r.row_sum = row_acc[DATA_W-1:0];
    end
    next_row = {1'b0, cur_row} + 17'd1;
    cur_row = (next_row >= {1'b0, rows}) ? '0 : next_row[ROW_W-1:0];
    row_acc = '0;
    bad_seen = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] random_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      default: begin
        case ($urandom_range(0, 4))
          0: return SUM_MAX;
          1: return SUM_MIN;
          2: return '1;
          3: return 32'h0001_0000;
          default: return 32'h0000_0001;
        endcase
      end
    endcase
  endfunction

  // Valid columns only ever point at written entries
  function automatic logic [COL_W-1:0] pick_column();
    int unsigned c;
    case ($urandom_range(0, 9))
      0: return COL_PADDING;
      1: begin
        if (vlen < STORE_DEPTH && $urandom_range(0, 1) == 1)
          return COL_W'($urandom_range(vlen, STORE_DEPTH - 1));
        return {1'b1, 10'($urandom_range(0, 1022))};
      end
      default: begin
        c = $urandom_range(0, vlen - 1);
        while (!vec_written[c]) c--;
        return COL_W'(c);
      end
    endcase
  endfunction

  task automatic send_word(input in_word_t w, input bit typed, input row_word_t typed_row);
    row_word_t r;
    if (!calm && !tx_calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= w.kind;
    vector_index_i <= w.vidx;
    column_index_i <= w.col;
    data_value_i   <= w.data;
    last_in_row_i  <= w.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (predict_row_sum(w, r)) expected_rows.push_back(typed ? typed_row : r);
    tx_count++;
    if (tx_count % 30 == 0) tx_calm = ($urandom_range(0, 2) == 0);
  endtask

  task automatic set_config(input logic [LEN_W-1:0] len, input logic [ROW_W-1:0] row_cfg);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_VECTOR_LENGTH;
    cfg_data_i  <= CFG_DAT_W'(len);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    vlen = len;
    cfg_index_i <= CFG_ROW_COUNT;
    cfg_data_i  <= row_cfg;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    rows = row_cfg;
    cfg_valid_i <= 1'b0;
  endtask

  // Hold until every row is out, then let any trailing slots clear the pipeline
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic vec(input int unsigned idx, input logic [DATA_W-1:0] val, input logic last);
    directed_words.push_back('{KIND_VEC_WRITE, VIDX_W'(idx), '0, val, last});
    directed_typed.push_back(1'b0);
    directed_rows.push_back('0);
  endtask

  task automatic slot(input logic [COL_W-1:0] col, input logic [DATA_W-1:0] val,
                      input logic last);
    directed_words.push_back('{KIND_SLOT, '0, col, val, last});
    directed_typed.push_back(1'b0);
    directed_rows.push_back('0);
  endtask

  task automatic slot_row(input logic [COL_W-1:0] col, input logic [DATA_W-1:0] val,
                          input logic [ROW_W-1:0] rn, input logic [DATA_W-1:0] total,
                          input logic ovf, input logic bad);
    directed_words.push_back('{KIND_SLOT, '0, col, val, 1'b1});
    directed_typed.push_back(1'b1);
    directed_rows.push_back('{rn, total, ovf, bad});
  endtask

  task automatic run_random(input int unsigned items);
    int unsigned sent;
    int unsigned len;
    in_word_t    w;
    sent = 0;
    while (sent < items) begin
      w.vidx = VIDX_W'($urandom_range(0, STORE_DEPTH - 1));
      w.col  = COL_W'($urandom);
      w.last = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0) begin
        w.kind = KIND_VEC_WRITE;
        if ($urandom_range(0, 1) == 1) w.vidx = VIDX_W'($urandom_range(0, vlen - 1));
        w.data = random_value();
        send_word(w, 1'b0, '0);
        sent++;
      end else begin
        len = $urandom_range(1, 6);
        for (int s = 0; s < len; s++) begin
          w.kind = KIND_SLOT;
          w.vidx = VIDX_W'($urandom_range(0, STORE_DEPTH - 1));
          w.col  = pick_column();
          w.data = random_value();
          w.last = (s == len - 1);
          send_word(w, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  task automatic report_row(input string what, input row_word_t want, input row_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected row %0d sum %h ovf %b bad %b, got row %0d sum %h ovf %b bad %b",
               what, want.row_number, want.row_sum, want.overflow, want.bad_index,
               got.row_number, got.row_sum, got.overflow, got.bad_index);
  endtask

  // Receiver: random stall bursts, calm stretches, and one long hold on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode_left = 40;
        rx_calm = ($urandom_range(0, 2) == 0);
      end
      rx_mode_left--;
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!rx_calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each delivered row word with the oldest expectation
  always @(posedge clk_i) begin
    row_word_t got;
    row_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{row_number_o, row_sum_o, overflow_o, bad_index_o};
      if (expected_rows.size() == 0) begin
        report_row("unexpected row word", '0, got);
      end else begin
        want = expected_rows.pop_front();
        if (got.row_number !== want.row_number || got.row_sum !== want.row_sum ||
            got.overflow !== want.overflow || got.bad_index !== want.bad_index)
          report_row("row word mismatch", want, got);
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles = 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stuck_cycles++;
    end
  end

  initial begin
    row_acc  = '0;
    cur_row  = '0;
    bad_seen = 1'b0;
    vlen     = VLEN_RESET;
    rows     = ROWS_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at reset settings: 1024 columns, a single row that wraps every time
    vec(0, 32'h0001_0000, 1'b0);
    vec(1023, 32'h0002_0000, 1'b0);
    vec(5, 32'hFFFF_0000, 1'b0);
    vec(6, SUM_MAX, 1'b0);
    vec(7, SUM_MIN, 1'b0);
    vec(8, 32'h0000_0001, 1'b1);                         // last flag ignored on a write
    slot_row(11'd0, 32'h0003_0000, '0, 32'h0003_0000, 1'b0, 1'b0);
    slot(11'd1023, 32'h0001_0000, 1'b0);
    slot(COL_PADDING, SUM_MAX, 1'b0);
    slot_row(11'd5, 32'h0001_0000, '0, 32'h0001_0000, 1'b0, 1'b0);
    slot(11'd6, SUM_MAX, 1'b0);
    slot_row(11'd6, SUM_MAX, '0, SUM_MAX, 1'b1, 1'b0);   // saturate high
    slot_row(11'd7, SUM_MAX, '0, SUM_MIN, 1'b1, 1'b0);   // saturate low
    slot_row(11'h7FE, 32'h0001_0000, '0, '0, 1'b0, 1'b1); // negative column
    slot(11'h400, SUM_MAX, 1'b0);
    slot_row(COL_PADDING, 32'h1234_5678, '0, '0, 1'b0, 1'b1);
    slot_row(COL_PADDING, 32'h1234_5678, '0, '0, 1'b0, 1'b0);
    slot(11'd7, SUM_MIN, 1'b0);
    slot(11'd7, SUM_MIN, 1'b0);
    slot(11'd7, SUM_MIN, 1'b0);
    slot_row(11'd7, SUM_MIN, '0, '0, 1'b0, 1'b0);         // accumulator wraps at 48 bits
    slot_row(11'd8, '1, '0, '1, 1'b0, 1'b0);              // truncation toward minus infinity
    slot_row(11'd8, 32'h0000_0001, '0, '0, 1'b0, 1'b0);
    for (int i = 0; i < directed_words.size(); i++)
      send_word(directed_words[i], directed_typed[i], directed_rows[i]);
    wait_drained();

    set_config(11'd1024, 16'd65535);
    hold_request = 1'b1;
    run_random(80);
    wait_drained();

    set_config(11'd1, 16'd3);
    run_random(60);
    wait_drained();

    set_config(11'd17, 16'd1);
    run_random(60);
    wait_drained();

    set_config(LEN_W'($urandom_range(1, 1024)), ROW_W'($urandom_range(1, 20)));
    run_random(80);
    wait_drained();

    set_config(LEN_W'($urandom_range(1, 1024)), ROW_W'($urandom_range(1, 65535)));
    run_random(80);
    wait_drained();

    // Closing stretch with both sides flowing freely
    calm = 1'b1;
    set_config(11'd1024, 16'd5);
    run_random(90);
    wait_drained();

    mismatches += expected_rows.size();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
